[rtl/gfp_pkg.sv]
package gfp_pkg;

  // Frame geometry default
  localparam int FrameBytesDef = 11;

  // Header and frame type codes
  localparam logic [7:0] HeaderByte = 8'h55;
  localparam logic [7:0] TypeAngle  = 8'h53;
  localparam logic [7:0] TypeRate   = 8'h52;

  // Fixed-point scaling: yaw = floor(raw*45/32), rate = floor(raw*125/128)
  localparam int YawMul    = 45;
  localparam int YawShift  = 5;
  localparam int RateMul   = 125;
  localparam int RateShift = 7;

  localparam int YawW  = 17;
  localparam int RateW = 16;

  typedef enum logic [2:0] {
    StAngleOk   = 3'd0,
    StRateOk    = 3'd1,
    StShort     = 3'd2,
    StLong      = 3'd3,
    StBadSum    = 3'd4,
    StBadHeader = 3'd5,
    StBadType   = 3'd6
  } status_e;

  // Frame as it stands after the current byte is taken in
  typedef struct packed {
    logic       short_f;
    logic       long_f;
    logic [7:0] sum;
    logic [7:0] hdr;
    logic [7:0] typ;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] b6;
    logic [7:0] b7;
    logic [7:0] chk;
  } frame_view_t;

  // Check outcome and converted values
  typedef struct packed {
    status_e                   status;
    logic                      upd_yaw;
    logic                      upd_rate;
    logic signed [YawW-1:0]    yaw;
    logic signed [RateW-1:0]   y_rate;
    logic signed [RateW-1:0]   z_rate;
  } check_res_t;

endpackage

[rtl/gfp_frame_buf.sv]
module gfp_frame_buf import gfp_pkg::*; #(
  parameter int FRAME_BYTES = FrameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic [7:0]  byte_i,
  input  logic        end_i,
  output frame_view_t view_o
);

  localparam int CntW = $clog2(FRAME_BYTES + 2);
  localparam int IdxW = $clog2(FRAME_BYTES);
  localparam logic [CntW-1:0] CntFull = CntW'(FRAME_BYTES);
  localparam logic [CntW-1:0] CntSum  = CntW'(FRAME_BYTES - 1);

  logic [7:0]      store_q [FRAME_BYTES];
  logic [CntW-1:0] cnt_q, cnt_d, cnt_nx;
  logic [7:0]      sum_q, sum_d, sum_nx;
  logic            in_store;

  // Byte at a fixed place, with the incoming byte forwarded
  function automatic logic [7:0] pick(input logic [CntW-1:0] cnt, input logic [7:0] b,
                                      input logic [7:0] stored, input int k);
    return (cnt == CntW'(k)) ? b : stored;
  endfunction

  assign in_store = (cnt_q < CntFull);
  assign sum_nx   = (cnt_q < CntSum) ? sum_q + byte_i : sum_q;
  assign cnt_nx   = (cnt_q <= CntFull) ? cnt_q + 1'b1 : cnt_q;

  // Count and sum clear at every burst end
  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    if (adv_i) begin
      cnt_d = end_i ? '0 : cnt_nx;
      sum_d = end_i ? '0 : sum_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
    end
  end

  // Frame store, written in arrival order
  always_ff @(posedge clk_i) begin
    if (adv_i && in_store) begin
      store_q[cnt_q[IdxW-1:0]] <= byte_i;
    end
  end

  always_comb begin
    view_o.short_f = (cnt_nx < CntFull);
    view_o.long_f  = (cnt_nx > CntFull);
    view_o.sum     = sum_nx;
    view_o.hdr     = pick(cnt_q, byte_i, store_q[0], 0);
    view_o.typ     = pick(cnt_q, byte_i, store_q[1], 1);
    view_o.b4      = pick(cnt_q, byte_i, store_q[4], 4);
    view_o.b5      = pick(cnt_q, byte_i, store_q[5], 5);
    view_o.b6      = pick(cnt_q, byte_i, store_q[6], 6);
    view_o.b7      = pick(cnt_q, byte_i, store_q[7], 7);
    view_o.chk     = pick(cnt_q, byte_i, store_q[FRAME_BYTES-1], FRAME_BYTES - 1);
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FRAME_BYTES + 1))
    else $error("byte count beyond saturation");
`endif

endmodule

[rtl/gfp_frame_check.sv]
module gfp_frame_check import gfp_pkg::*; (
  input  frame_view_t view_i,
  output check_res_t  res_o
);

  localparam int YawPW  = 22;
  localparam int RatePW = 23;

  logic signed [15:0]       yaw_raw, yr_raw, zr_raw;
  logic signed [YawPW-1:0]  yaw_p;
  logic signed [RatePW-1:0] yr_p, zr_p;

  assign yaw_raw = {view_i.b7, view_i.b6};
  assign yr_raw  = {view_i.b5, view_i.b4};
  assign zr_raw  = {view_i.b7, view_i.b6};

  // Scale by constant; arithmetic shift floors
  assign yaw_p = YawPW'(yaw_raw) * YawPW'(YawMul);
  assign yr_p  = RatePW'(yr_raw) * RatePW'(RateMul);
  assign zr_p  = RatePW'(zr_raw) * RatePW'(RateMul);

  // Checks in priority order: length, sum, header, type
  always_comb begin
    res_o.yaw      = yaw_p[YawShift +: YawW];
    res_o.y_rate   = yr_p[RateShift +: RateW];
    res_o.z_rate   = zr_p[RateShift +: RateW];
    res_o.upd_yaw  = 1'b0;
    res_o.upd_rate = 1'b0;
    if (view_i.short_f) begin
      res_o.status = StShort;
    end else if (view_i.long_f) begin
      res_o.status = StLong;
    end else if (view_i.sum != view_i.chk) begin
      res_o.status = StBadSum;
    end else if (view_i.hdr != HeaderByte) begin
      res_o.status = StBadHeader;
    end else if (view_i.typ == TypeAngle) begin
      res_o.status  = StAngleOk;
      res_o.upd_yaw = 1'b1;
    end else if (view_i.typ == TypeRate) begin
      res_o.status   = StRateOk;
      res_o.upd_rate = 1'b1;
    end else begin
      res_o.status = StBadType;
    end
  end

endmodule

[rtl/gyro_frame_parser.sv]
// Path: a burst-end byte's result reaches the outputs through the input register,
// then the result register.
// Throughput: one byte per cycle; the input register frees while a result waits
// in the output register, and only a second burst-end byte stalls behind it.
// Reset: asynchronous, active low; clears byte count, running sum, held yaw and
// rates and all valid flags. Frame store bytes need no reset.
module gyro_frame_parser import gfp_pkg::*; #(
  parameter int FRAME_BYTES = FrameBytesDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              rx_byte_i,
  input  logic                    burst_end_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2:0]              status_o,
  output logic signed [YawW-1:0]  yaw_angle_o,
  output logic signed [RateW-1:0] y_rate_o,
  output logic signed [RateW-1:0] z_rate_o
);

  logic                    s1_valid_q, s1_valid_d;
  logic [7:0]              s1_byte_q;
  logic                    s1_end_q;
  logic                    out_valid_q, out_valid_d;
  status_e                 status_q;
  logic signed [YawW-1:0]  held_yaw_q, held_yaw_d;
  logic signed [RateW-1:0] held_yr_q, held_yr_d;
  logic signed [RateW-1:0] held_zr_q, held_zr_d;
  logic                    in_acc, blocked, adv, load;
  frame_view_t             view;
  check_res_t              res;

  // Handshake: only a burst-end byte waits on a full, stalled output
  assign blocked    = s1_end_q && out_valid_q && out_stall_i;
  assign in_stall_o = s1_valid_q && blocked;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign adv        = s1_valid_q && !blocked;
  assign load       = adv && s1_end_q;

  // Input register
  assign s1_valid_d = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= rx_byte_i;
      s1_end_q  <= burst_end_i;
    end
  end

  gfp_frame_buf #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (s1_byte_q),
    .end_i  (s1_end_q),
    .view_o (view)
  );

  gfp_frame_check u_check (
    .view_i (view),
    .res_o  (res)
  );

  // Held values and result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    held_yaw_d  = held_yaw_q;
    held_yr_d   = held_yr_q;
    held_zr_d   = held_zr_q;
    if (load) begin
      out_valid_d = 1'b1;
      if (res.upd_yaw) begin
        held_yaw_d = res.yaw;
      end
      if (res.upd_rate) begin
        held_yr_d = res.y_rate;
        held_zr_d = res.z_rate;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_yaw_q  <= '0;
      held_yr_q   <= '0;
      held_zr_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      held_yaw_q  <= held_yaw_d;
      held_yr_q   <= held_yr_d;
      held_zr_q   <= held_zr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign yaw_angle_o = held_yaw_q;
  assign y_rate_o    = held_yr_q;
  assign z_rate_o    = held_zr_q;

`ifndef SYNTHESIS
  a_out_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(load))
    else $error("result appeared without a burst-end byte");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_end_q && out_valid_q))
    else $error("input stalled without a waiting result");

  a_rate_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load && res.upd_rate) |=> ($stable(held_yr_q) && $stable(held_zr_q)))
    else $error("held rates changed without a rate frame");

  a_yaw_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load && res.upd_yaw) |=> $stable(held_yaw_q))
    else $error("held yaw changed without an angle frame");
`endif

endmodule

[test/gyro_frame_parser_tb.sv]
module gyro_frame_parser_tb;
  import gfp_pkg::*;

  localparam int FRAME_BYTES    = FrameBytesDef;
  localparam int RANDOM_ITEMS   = 200;
  localparam int RANDOM_BURSTS  = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 5000;

  // One parser result as seen on the output side
  typedef struct packed {
    status_e                 status;
    logic signed [YawW-1:0]  yaw;
    logic signed [RateW-1:0] y_rate;
    logic signed [RateW-1:0] z_rate;
  } parse_res_t;

  // Directed burst: frame layout, corruption and optional typed-in result
  typedef struct {
    int          len;
    logic [7:0]  hdr;
    logic [7:0]  typ;
    logic [15:0] w45;
    logic [15:0] w67;
    bit          bad_sum;
    bit          typed;
    parse_res_t  res;
  } dir_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [7:0]              rx_byte_i;
  logic                    burst_end_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [2:0]              status_o;
  logic signed [YawW-1:0]  yaw_angle_o;
  logic signed [RateW-1:0] y_rate_o;
  logic signed [RateW-1:0] z_rate_o;

  // Typed-in expectation travels with the payload of the last byte
  logic       tag_typed;
  parse_res_t tag_exp;

  parse_res_t pending_results[$];
  logic [7:0] burst_bytes[$];
  dir_row_t   dir_rows[$];
  int         mismatches = 0;
  int         run_left = 0;
  int         idle_cycles = 0;
  bit         hold_req = 1'b0;

  // Predictor state
  logic [7:0]              frm [FRAME_BYTES];
  int                      frm_cnt;
  logic [7:0]              frm_sum;
  logic signed [YawW-1:0]  held_yaw;
  logic signed [RateW-1:0] held_y_rate;
  logic signed [RateW-1:0] held_z_rate;

  gyro_frame_parser uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .burst_end_i (burst_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .yaw_angle_o (yaw_angle_o),
    .y_rate_o    (y_rate_o),
    .z_rate_o    (z_rate_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Fixed-point conversions, floored by arithmetic shift
  function automatic logic signed [YawW-1:0] to_yaw(input logic [15:0] w);
    int p;
    p = $signed(w) * YawMul;
    return YawW'(p >>> YawShift);
  endfunction

  function automatic logic signed [RateW-1:0] to_rate(input logic [15:0] w);
    int p;
    p = $signed(w) * RateMul;
    return RateW'(p >>> RateShift);
  endfunction

  task automatic reset_predictor();
    for (int i = 0; i < FRAME_BYTES; i++) frm[i] = 8'h00;
    frm_cnt     = 0;
    frm_sum     = 8'h00;
    held_yaw    = '0;
    held_y_rate = '0;
    held_z_rate = '0;
  endtask

  // Take one byte into the predicted frame; on burst end, check and report
  task automatic parse_byte(input logic [7:0] b, input logic last,
                            output parse_res_t r, output bit produced);
    status_e st;
    if (frm_cnt < FRAME_BYTES) begin
      frm[frm_cnt] = b;
      if (frm_cnt < FRAME_BYTES - 1) frm_sum = frm_sum + b;
    end
    if (frm_cnt <= FRAME_BYTES) frm_cnt++;
    produced = last;
    r = '0;
    if (last) begin
      if (frm_cnt < FRAME_BYTES) st = StShort;
      else if (frm_cnt > FRAME_BYTES) st = StLong;
      else if (frm_sum != frm[FRAME_BYTES-1]) st = StBadSum;
      else if (frm[0] != HeaderByte) st = StBadHeader;
      else if (frm[1] == TypeAngle) begin
        held_yaw = to_yaw({frm[7], frm[6]});
        st = StAngleOk;
      end else if (frm[1] == TypeRate) begin
        held_y_rate = to_rate({frm[5], frm[4]});
        held_z_rate = to_rate({frm[7], frm[6]});
        st = StRateOk;
      end else st = StBadType;
      frm_cnt = 0;
      frm_sum = 8'h00;
      r = '{st, held_yaw, held_y_rate, held_z_rate};
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Scoreboard: predict on input transactions, compare on output transactions
  always @(posedge clk_i) begin : scoreboard
    parse_res_t pred;
    parse_res_t want;
    bit         produced;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        parse_byte(rx_byte_i, burst_end_i, pred, produced);
        if (produced) pending_results.push_back(tag_typed ? tag_exp : pred);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with none pending, status", status_o, 0);
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", status_o, want.status);
          if (yaw_angle_o !== want.yaw)
            report_mismatch("yaw_angle", yaw_angle_o, want.yaw);
          if (y_rate_o !== want.y_rate)
            report_mismatch("y_rate", y_rate_o, want.y_rate);
          if (z_rate_o !== want.z_rate)
            report_mismatch("z_rate", z_rate_o, want.z_rate);
        end
      end
    end
  end

  // Watchdog: cycles in which neither side completes a transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("gyro_frame_parser verification failed");
      $finish;
    end
  end

  // Receiver: stall patterns in segments, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int seg;
    out_stall_i = 1'b0;
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(20, 80);
        for (int k = 0; k < seg; k++) begin
          case (mode)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= 1'($urandom_range(0, 1));
            2: out_stall_i <= (k % 4) != 0;
            default: out_stall_i <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Checksum over bytes 0..FRAME_BYTES-2 into the last frame byte
  task automatic seal_frame();
    logic [7:0] s;
    s = 8'h00;
    for (int i = 0; i < FRAME_BYTES - 1; i++) s = s + burst_bytes[i];
    burst_bytes[FRAME_BYTES-1] = s;
  endtask

  task automatic resize_burst(input int len);
    while (burst_bytes.size() > len) void'(burst_bytes.pop_back());
    while (burst_bytes.size() < len) burst_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offer one byte and wait for its transaction; sender runs in bursts with gaps
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic typed, input parse_res_t res);
    int gap;
    in_valid_i  <= 1'b1;
    rx_byte_i   <= b;
    burst_end_i <= last;
    tag_typed   <= typed;
    tag_exp     <= res;
    do @(posedge clk_i); while (in_stall_o);
    if (run_left == 0) begin
      run_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      run_left--;
    end
  endtask

  task automatic send_burst(input bit typed, input parse_res_t res);
    int last_idx;
    last_idx = burst_bytes.size() - 1;
    for (int i = 0; i <= last_idx; i++)
      send_byte(burst_bytes[i], i == last_idx, typed && (i == last_idx), res);
  endtask

  task automatic make_random_burst();
    int         kind;
    int         len;
    logic [7:0] typ;
    logic [15:0] w45;
    logic [15:0] w67;
    burst_bytes.delete();
    kind = $urandom_range(0, 99);
    for (int i = 0; i < FRAME_BYTES; i++) burst_bytes.push_back(8'($urandom_range(0, 255)));
    if (kind < 80) begin
      // well-formed frame, sometimes broken in one place
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: typ = TypeAngle;
        5, 6, 7, 8:    typ = TypeRate;
        default:       typ = 8'($urandom_range(0, 255));
      endcase
      w45 = pick_word();
      w67 = pick_word();
      burst_bytes[0] = HeaderByte;
      burst_bytes[1] = typ;
      burst_bytes[4] = w45[7:0];
      burst_bytes[5] = w45[15:8];
      burst_bytes[6] = w67[7:0];
      burst_bytes[7] = w67[15:8];
      seal_frame();
      if (kind >= 70) begin
        case ($urandom_range(0, 2))
          0: burst_bytes[FRAME_BYTES-1] += 8'($urandom_range(1, 255));
          1: begin
            burst_bytes[0] ^= 8'($urandom_range(1, 255));
            seal_frame();
          end
          default: resize_burst($urandom_range(0, 1) ? FRAME_BYTES - 1 : FRAME_BYTES + 1);
        endcase
      end
    end else if (kind < 90) begin
      // wrong length noise
      len = $urandom_range(1, 15);
      if (len >= FRAME_BYTES) len++;
      resize_burst(len);
      if ($urandom_range(0, 1)) burst_bytes[0] = HeaderByte;
    end
  endtask

  // Main stimulus: directed bursts, then random bursts
  initial begin : stimulus
    int       rnd_items;
    int       rnd_bursts;
    dir_row_t row;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    burst_end_i = 1'b0;
    tag_typed   = 1'b0;
    tag_exp     = '0;
    reset_predictor();

    // len, header, type, bytes 4..5, bytes 6..7, bad sum, typed, result
    dir_rows.push_back('{1, HeaderByte, TypeAngle, 16'h0000, 16'h0000, 0, 1,
                         '{StShort, 17'sd0, 16'sd0, 16'sd0}});
    dir_rows.push_back('{FRAME_BYTES - 1, HeaderByte, TypeAngle, 16'h7FFF, 16'h7FFF, 0, 1,
                         '{StShort, 17'sd0, 16'sd0, 16'sd0}});
    dir_rows.push_back('{FRAME_BYTES + 1, HeaderByte, TypeAngle, 16'h7FFF, 16'h7FFF, 0, 1,
                         '{StLong, 17'sd0, 16'sd0, 16'sd0}});
    dir_rows.push_back('{40, HeaderByte, TypeRate, 16'h1234, 16'h4321, 0, 1,
                         '{StLong, 17'sd0, 16'sd0, 16'sd0}});
    dir_rows.push_back('{FRAME_BYTES, HeaderByte, TypeAngle, 16'h7FFF, 16'h7FFF, 1, 1,
                         '{StBadSum, 17'sd0, 16'sd0, 16'sd0}});
    dir_rows.push_back('{FRAME_BYTES, 8'hAA, TypeAngle, 16'h7FFF, 16'h7FFF, 0, 1,
                         '{StBadHeader, 17'sd0, 16'sd0, 16'sd0}});
    dir_rows.push_back('{FRAME_BYTES, HeaderByte, 8'h00, 16'h7FFF, 16'h7FFF, 0, 1,
                         '{StBadType, 17'sd0, 16'sd0, 16'sd0}});
    dir_rows.push_back('{FRAME_BYTES, HeaderByte, TypeAngle, 16'h0000, 16'h7FFF, 0, 1,
                         '{StAngleOk, 17'sd46078, 16'sd0, 16'sd0}});
    dir_rows.push_back('{FRAME_BYTES, HeaderByte, TypeAngle, 16'h0000, 16'h8000, 0, 1,
                         '{StAngleOk, -17'sd46080, 16'sd0, 16'sd0}});
    dir_rows.push_back('{FRAME_BYTES, HeaderByte, TypeRate, 16'h7FFF, 16'h8000, 0, 1,
                         '{StRateOk, -17'sd46080, 16'sd31999, -16'sd32000}});
    dir_rows.push_back('{FRAME_BYTES, HeaderByte, TypeRate, 16'hFFFF, 16'h0001, 0, 1,
                         '{StRateOk, -17'sd46080, -16'sd1, 16'sd0}});
    dir_rows.push_back('{FRAME_BYTES, HeaderByte, TypeAngle, 16'h0000, 16'hFFFF, 0, 1,
                         '{StAngleOk, -17'sd2, -16'sd1, 16'sd0}});
    // sum checked before header
    dir_rows.push_back('{FRAME_BYTES, 8'h00, TypeAngle, 16'h0000, 16'h7FFF, 1, 1,
                         '{StBadSum, -17'sd2, -16'sd1, 16'sd0}});
    dir_rows.push_back('{FRAME_BYTES, HeaderByte, TypeAngle, 16'h5A5A, 16'h1234, 0, 0, '0});
    dir_rows.push_back('{FRAME_BYTES, HeaderByte, 8'h51, 16'h0F0F, 16'hF0F0, 0, 0, '0});
    dir_rows.push_back('{FRAME_BYTES, HeaderByte, TypeRate, 16'h0100, 16'hFEFF, 0, 0, '0});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      burst_bytes = '{row.hdr, row.typ, 8'h00, 8'h00, row.w45[7:0], row.w45[15:8],
                      row.w67[7:0], row.w67[15:8], 8'h00, 8'h00, 8'h00};
      seal_frame();
      if (row.bad_sum) burst_bytes[FRAME_BYTES-1] += 8'h01;
      resize_burst(row.len);
      send_burst(row.typed, row.res);
    end

    rnd_items  = 0;
    rnd_bursts = 0;
    while (rnd_items < RANDOM_ITEMS || rnd_bursts < RANDOM_BURSTS) begin
      // long output hold-off while input keeps coming
      if (rnd_bursts == 4) hold_req = 1'b1;
      // sender pause until the output side has caught up
      if (rnd_bursts == 16) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      make_random_burst();
      rnd_items += burst_bytes.size();
      send_burst(1'b0, '0);
      rnd_bursts++;
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("gyro_frame_parser verification clean");
    end else begin
      $display("gyro_frame_parser verification failed");
    end
    $finish;
  end

endmodule
